/* design/cbm_pkg.sv */
// ----------------------------------------------------------------------------
// cbm_pkg: shared types and constants for the cartridge bank mapper
// Command codes, mapper modes, register indexes and the ROM size mask.
// ----------------------------------------------------------------------------
package cbm_pkg;

	localparam int unsigned RAM_DEPTH_DEF = 512;
	localparam int unsigned BANK_SHIFT    = 14;
	localparam int unsigned ADDR_W        = 16;
	localparam int unsigned ROM_IDX_W     = 19;
	localparam int unsigned BANK_W        = 5;
	localparam int unsigned CFG_IDX_W     = 1;
	localparam int unsigned CFG_DATA_W    = 5;

	localparam logic [4:0] ROM_LG_MIN = 5'd15;
	localparam logic [4:0] ROM_LG_MAX = 5'd19;

	typedef enum logic [1:0] {
		CMD_ROM_RD = 2'd0,
		CMD_ROM_WR = 2'd1,
		CMD_RAM_RD = 2'd2,
		CMD_RAM_WR = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		MODE_NONE = 2'd0,
		MODE_MBC1 = 2'd1,
		MODE_MBC2 = 2'd2
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAPPER_MODE = 1'b0,
		REG_ROM_SIZE    = 1'b1
	} reg_idx_t;

	// Control window of a ROM write, address bits 14:13
	localparam logic [1:0] WIN_RAM_EN = 2'b00;
	localparam logic [1:0] WIN_BANK   = 2'b01;

	// Index mask for a ROM of 2^lg bytes, lg clamped to the supported range
	function automatic logic [ROM_IDX_W-1:0] rom_mask(input logic [4:0] lg);
		logic [4:0] c;
		c = lg;
		if (c < ROM_LG_MIN) c = ROM_LG_MIN;
		if (c > ROM_LG_MAX) c = ROM_LG_MAX;
		rom_mask = (ROM_IDX_W'(1) << c) - ROM_IDX_W'(1);
	endfunction

endpackage

/* design/cartridge_bank_mapper_core.sv */
// ----------------------------------------------------------------------------
// cartridge_bank_mapper_core: MBC1 / MBC2 style cartridge bank controller
// Maps ROM bus accesses through the bank register and serves the MBC2 RAM.
// ----------------------------------------------------------------------------
// Every input beat is one bus access and yields exactly one output beat: the
// beat is captured in an input register at the edge it is taken, then mapped,
// applied to the bank state and the on-chip 512 x 8 RAM, and moves into the
// result register at the edge where that register is free, so a stalled result
// holds it in the input register. The block sustains one beat per cycle while
// the result side does not stall; the RAM is touched once per beat, at the edge
// where the beat moves into the result register, so reads always see every
// earlier write. After reset the RAM is swept to zero, one entry per cycle, and
// in_stall stays high until the sweep is done; configuration writes are taken
// throughout. The ROM itself lives outside: rom_index is the physical byte
// index, and rom_poke flags a debug write of value into that external ROM.
module cartridge_bank_mapper_core #(
	parameter int unsigned RAM_DEPTH = cbm_pkg::RAM_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration write channel
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [cbm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [cbm_pkg::CFG_DATA_W-1:0]    cfg_data,
	// access channel
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [1:0]                        command,
	input  logic [cbm_pkg::ADDR_W-1:0]        address,
	input  logic [7:0]                        value,
	input  logic                              bypass,
	// result channel
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [cbm_pkg::ROM_IDX_W-1:0]     rom_index,
	output logic                              rom_poke,
	output logic [7:0]                        read_data
);
	import cbm_pkg::*;

	localparam int unsigned RAM_AW = $clog2(RAM_DEPTH);

	// configuration and bank state
	logic [1:0]            mapper_mode_q;
	logic [4:0]            rom_size_log2_q;
	logic [BANK_W-1:0]     rom_bank_q;
	logic                  ram_en_q;

	// clearing sweep
	logic                  clr_q;
	logic [RAM_AW-1:0]     clr_cnt_q;

	// input stage
	logic                  valid_s1;
	cmd_t                  command_s1;
	logic [ADDR_W-1:0]     address_s1;
	logic [7:0]            value_s1;
	logic                  bypass_s1;

	// result stage
	logic                  valid_s2;
	logic [ROM_IDX_W-1:0]  rom_index_s2;
	logic                  rom_poke_s2;
	logic [7:0]            read_data_s2;

	logic [7:0]            mem [RAM_DEPTH];

	// handshake
	logic                  s2_free;
	logic                  adv;
	logic                  in_take;

	// stage-one logic
	logic                  banked;
	logic                  ram_on;
	logic [ROM_IDX_W-1:0]  idx_raw;
	logic [ROM_IDX_W-1:0]  rom_idx;
	logic                  is_rom;
	logic [RAM_AW-1:0]     ram_idx;
	logic                  ctl_wr;
	logic [1:0]            win;
	logic                  bank_wr;
	logic [BANK_W-1:0]     bank_val;
	logic                  ram_en_wr;
	logic                  ram_rd;

	// RAM write port
	logic                  mem_we;
	logic [RAM_AW-1:0]     mem_waddr;
	logic [7:0]            mem_wdata;

	// The result register frees up when empty or when its beat leaves.
	// Hold the input register while the result side stalls.
	assign s2_free  = ~valid_s2 | ~out_stall;
	assign adv      = valid_s1 & s2_free;
	assign in_stall = clr_q | (valid_s1 & ~adv);
	assign in_take  = in_valid & ~in_stall;
	assign cfg_ready = 1'b1;

	// Mode three has no meaning and falls through as no mapper.
	assign banked = (mapper_mode_q == MODE_MBC1) || (mapper_mode_q == MODE_MBC2);
	assign ram_on = (mapper_mode_q == MODE_MBC2) && ram_en_q;

	// Upper ROM window: drop bit 14 and OR in the bank above it.
	always_comb begin
		idx_raw = ROM_IDX_W'(address_s1);
		if (banked && address_s1[BANK_SHIFT]) begin
			idx_raw[BANK_SHIFT] = 1'b0;
			idx_raw = idx_raw | (ROM_IDX_W'(rom_bank_q) << BANK_SHIFT);
		end
	end

	assign is_rom  = (command_s1 == CMD_ROM_RD) || (command_s1 == CMD_ROM_WR);
	assign rom_idx = is_rom ? (idx_raw & rom_mask(rom_size_log2_q)) : '0;
	assign ram_idx = address_s1[RAM_AW-1:0];

	// Control writes land only on a ROM write that is not a debug poke.
	assign ctl_wr = (command_s1 == CMD_ROM_WR) && !bypass_s1;
	assign win    = address_s1[14:13];

	always_comb begin
		bank_wr   = 1'b0;
		ram_en_wr = 1'b0;
		bank_val  = BANK_W'(value_s1[4:0]);
		case (mapper_mode_q)
			MODE_MBC1: begin
				bank_wr  = ctl_wr && (win == WIN_BANK);
				bank_val = value_s1[4:0];
			end
			MODE_MBC2: begin
				bank_wr   = ctl_wr && (win == WIN_BANK);
				ram_en_wr = ctl_wr && (win == WIN_RAM_EN);
				bank_val  = {1'b0, value_s1[3:0]};
			end
			default: begin
			end
		endcase
		// bank zero selects bank one
		if (bank_val == '0) bank_val = BANK_W'(1);
	end

	assign ram_rd = (command_s1 == CMD_RAM_RD) && ram_on;

	// One write port, shared by the clearing sweep and RAM write beats.
	always_comb begin
		if (clr_q) begin
			mem_we    = 1'b1;
			mem_waddr = clr_cnt_q;
			mem_wdata = '0;
		end else begin
			mem_we    = adv && (command_s1 == CMD_RAM_WR) && ram_on;
			mem_waddr = ram_idx;
			mem_wdata = bypass_s1 ? value_s1 : {4'b0000, value_s1[3:0]};
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
	end

	// Read the RAM on the same edge the beat enters the result register.
	always_ff @(posedge clk) begin
		if (adv) begin
			rom_index_s2 <= rom_idx;
			rom_poke_s2  <= (command_s1 == CMD_ROM_WR) && bypass_s1;
			read_data_s2 <= ram_rd ? mem[ram_idx] : 8'h00;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_cnt_q <= '0;
		end else if (clr_q) begin
			clr_cnt_q <= clr_cnt_q + RAM_AW'(1);
			if (clr_cnt_q == RAM_AW'(RAM_DEPTH - 1)) clr_q <= 1'b0;
		end
	end

	// Configuration registers; unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mapper_mode_q   <= MODE_NONE;
			rom_size_log2_q <= ROM_LG_MIN;
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_idx_t'(cfg_index))
				REG_MAPPER_MODE: mapper_mode_q   <= cfg_data[1:0];
				REG_ROM_SIZE:    rom_size_log2_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Bank state changes on a control write beat, after that beat has been mapped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rom_bank_q <= BANK_W'(1);
			ram_en_q   <= 1'b0;
		end else if (adv) begin
			if (bank_wr)   rom_bank_q <= bank_val;
			if (ram_en_wr) ram_en_q   <= address_s1[8];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_take)      valid_s1 <= 1'b1;
			else if (adv)     valid_s1 <= 1'b0;
			if (adv)          valid_s2 <= 1'b1;
			else if (s2_free) valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			command_s1 <= cmd_t'(command);
			address_s1 <= address;
			value_s1   <= value;
			bypass_s1  <= bypass;
		end
	end

	assign out_valid = valid_s2;
	assign rom_index = rom_index_s2;
	assign rom_poke  = rom_poke_s2;
	assign read_data = read_data_s2;

endmodule

/* design/cbm_checker.sv */
// ----------------------------------------------------------------------------
// cbm_checker: port-level checks for the cartridge bank mapper
// Watches the top level's ports only; attached by the bind below.
// ----------------------------------------------------------------------------
module cbm_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic                              in_stall,
	input  logic [1:0]                        command,
	input  logic [cbm_pkg::ADDR_W-1:0]        address,
	input  logic [7:0]                        value,
	input  logic                              bypass,
	input  logic                              out_valid,
	input  logic                              out_stall,
	input  logic [cbm_pkg::ROM_IDX_W-1:0]     rom_index,
	input  logic                              rom_poke,
	input  logic [7:0]                        read_data
);
	// A new result appears only for a beat taken through the input register.
	a_rise_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall, 2))
		else $error("result appeared without a matching input beat");

	// A poke is a ROM write and never carries RAM data.
	a_poke_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && rom_poke |-> read_data == 8'h00)
		else $error("poke beat carries read data");

	// ROM beats carry an index, RAM beats carry data: never both.
	a_index_or_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (rom_index != '0) |-> read_data == 8'h00)
		else $error("beat carries both ROM index and RAM data");

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(rom_index)
			&& $stable(rom_poke) && $stable(read_data))
		else $error("stalled result changed");

	// A stalled access beat holds.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(command)
			&& $stable(address) && $stable(value) && $stable(bypass))
		else $error("stalled access beat changed");

endmodule

bind cartridge_bank_mapper_core cbm_checker u_cbm_checker (.*);

/* tb/sv/tb_cartridge_bank_mapper_core.sv */
// ----------------------------------------------------------------------------
// tb_cartridge_bank_mapper_core: self-checking bench for the bank mapper
// Drives bus access beats through directed rows and random mapper phases.
// A shadow copy of the bank register, the RAM enable flag and the MBC2 RAM
// predicts every untyped result beat, and each result is checked in order.
// ----------------------------------------------------------------------------
module tb_cartridge_bank_mapper_core;
	import cbm_pkg::*;

	// Mapper mode 3 has no meaning and must behave like no mapper
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	localparam int unsigned CLK_HALF       = 4;
	localparam int unsigned RESET_CYCLES   = 7;
	// The RAM sweep after reset holds off input beats until the RAM is cleared
	localparam int unsigned WATCHDOG_LIMIT = 4000;
	localparam int unsigned PHASES         = 8;
	localparam int unsigned PHASE_BEATS    = 250;
	localparam int unsigned IDLE_PCT       = 18;

	typedef struct packed {
		logic [ROM_IDX_W-1:0] rom_index;
		logic                 rom_poke;
		logic [7:0]           read_data;
	} access_result_t;

	// One directed beat plus the configuration it runs under. Rows with
	// typed set carry an expected result that is obvious by inspection.
	typedef struct packed {
		logic [1:0]     mode;
		logic [4:0]     rom_lg;
		cmd_t           cmd;
		logic [15:0]    addr;
		logic [7:0]     val;
		logic           byp;
		logic           typed;
		access_result_t res;
	} stim_row_t;

	localparam access_result_t NO_RESULT = '{19'h0, 1'b0, 8'h00};

	localparam stim_row_t STIM_ROWS [25] = '{
		// after reset: no mapper, 32 KiB ROM
		'{MODE_NONE, 5'd15, CMD_ROM_RD, 16'hFFFF, 8'h00, 1'b0, 1'b1, '{19'h07FFF, 1'b0, 8'h00}},
		'{MODE_NONE, 5'd15, CMD_RAM_RD, 16'h0000, 8'h00, 1'b0, 1'b1, NO_RESULT},
		'{MODE_NONE, 5'd15, CMD_ROM_WR, 16'h2000, 8'hFF, 1'b0, 1'b1, '{19'h02000, 1'b0, 8'h00}},
		'{MODE_NONE, 5'd15, CMD_ROM_WR, 16'h4123, 8'hAA, 1'b1, 1'b1, '{19'h04123, 1'b1, 8'h00}},
		// MBC1, largest ROM: bank reset value, bank zero, full bank
		'{MODE_MBC1, 5'd19, CMD_ROM_RD, 16'h4000, 8'h00, 1'b0, 1'b1, '{19'h04000, 1'b0, 8'h00}},
		'{MODE_MBC1, 5'd19, CMD_ROM_WR, 16'h2000, 8'h00, 1'b0, 1'b1, '{19'h02000, 1'b0, 8'h00}},
		'{MODE_MBC1, 5'd19, CMD_ROM_WR, 16'h3FFF, 8'h1F, 1'b0, 1'b1, '{19'h03FFF, 1'b0, 8'h00}},
		'{MODE_MBC1, 5'd19, CMD_ROM_RD, 16'h7FFF, 8'h00, 1'b0, 1'b1, '{19'h7FFFF, 1'b0, 8'h00}},
		'{MODE_MBC1, 5'd19, CMD_ROM_RD, 16'hFFFF, 8'h00, 1'b0, 1'b0, NO_RESULT},
		'{MODE_MBC1, 5'd19, CMD_ROM_WR, 16'h0100, 8'h00, 1'b0, 1'b1, '{19'h00100, 1'b0, 8'h00}},
		'{MODE_MBC1, 5'd19, CMD_ROM_WR, 16'h6000, 8'h55, 1'b1, 1'b0, NO_RESULT},
		'{MODE_MBC1, 5'd19, CMD_RAM_WR, 16'h0010, 8'hFF, 1'b0, 1'b1, NO_RESULT},
		// MBC2, ROM size below range: bank mask, RAM enable, masked RAM data
		'{MODE_MBC2, 5'd0,  CMD_ROM_WR, 16'h2100, 8'hFF, 1'b0, 1'b0, NO_RESULT},
		'{MODE_MBC2, 5'd0,  CMD_ROM_RD, 16'h4000, 8'h00, 1'b0, 1'b0, NO_RESULT},
		'{MODE_MBC2, 5'd0,  CMD_RAM_RD, 16'h01FF, 8'h00, 1'b0, 1'b1, NO_RESULT},
		'{MODE_MBC2, 5'd0,  CMD_RAM_WR, 16'h0005, 8'hAB, 1'b0, 1'b0, NO_RESULT},
		'{MODE_MBC2, 5'd0,  CMD_ROM_WR, 16'h0100, 8'h00, 1'b0, 1'b0, NO_RESULT},
		'{MODE_MBC2, 5'd0,  CMD_RAM_RD, 16'h0005, 8'h00, 1'b0, 1'b0, NO_RESULT},
		'{MODE_MBC2, 5'd0,  CMD_RAM_WR, 16'h01FF, 8'hAB, 1'b0, 1'b0, NO_RESULT},
		'{MODE_MBC2, 5'd0,  CMD_RAM_RD, 16'hFFFF, 8'h00, 1'b0, 1'b0, NO_RESULT},
		'{MODE_MBC2, 5'd0,  CMD_RAM_WR, 16'h0200, 8'hCD, 1'b1, 1'b0, NO_RESULT},
		'{MODE_MBC2, 5'd0,  CMD_RAM_RD, 16'h0000, 8'h00, 1'b0, 1'b0, NO_RESULT},
		'{MODE_MBC2, 5'd0,  CMD_ROM_WR, 16'h0000, 8'h00, 1'b0, 1'b0, NO_RESULT},
		// undefined mode, ROM size above range
		'{MODE_UNUSED, 5'd31, CMD_ROM_RD, 16'hFFFF, 8'h00, 1'b0, 1'b1, '{19'h0FFFF, 1'b0, 8'h00}},
		'{MODE_UNUSED, 5'd31, CMD_RAM_RD, 16'h0000, 8'h00, 1'b0, 1'b1, NO_RESULT}
	};

	// Random phases walk every mode and both ends of the ROM size range
	localparam logic [1:0] PHASE_MODE [PHASES] = '{
		MODE_MBC2, MODE_MBC1, MODE_MBC2, MODE_NONE,
		MODE_MBC2, MODE_MBC1, MODE_UNUSED, MODE_MBC2
	};
	localparam logic [4:0] PHASE_LG [PHASES] = '{
		5'd15, 5'd19, 5'd17, 5'd0, 5'd18, 5'd16, 5'd31, 5'd19
	};

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [1:0]           command = '0;
	logic [ADDR_W-1:0]    address = '0;
	logic [7:0]           value = '0;
	logic                 bypass = 1'b0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [ROM_IDX_W-1:0] rom_index;
	logic                 rom_poke;
	logic [7:0]           read_data;

	// Typed expectation that travels with the access beat on the bus
	logic                 beat_typed = 1'b0;
	access_result_t       beat_result = '0;

	// Shadow of the block's registers and RAM
	logic [1:0]           shadow_mode = MODE_NONE;
	logic [4:0]           shadow_rom_lg = ROM_LG_MIN;
	logic [BANK_W-1:0]    shadow_bank = 5'd1;
	logic                 shadow_ram_en = 1'b0;
	logic [7:0]           shadow_ram [RAM_DEPTH_DEF];

	access_result_t       pending_results [$];
	int unsigned          errors = 0;
	int unsigned          quiet_cycles = 0;
	bit                   no_idle = 1'b0;

	cartridge_bank_mapper_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.command   (command),
		.address   (address),
		.value     (value),
		.bypass    (bypass),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.rom_index (rom_index),
		.rom_poke  (rom_poke),
		.read_data (read_data)
	);

	always #(CLK_HALF) clk = ~clk;

	initial begin
		foreach (shadow_ram[i]) shadow_ram[i] = 8'h00;
	end

	// Physical ROM byte index: swap bit 14 for the bank in a mapper mode,
	// then mask to the ROM size clamped to 32 KiB .. 512 KiB
	function automatic logic [ROM_IDX_W-1:0] physical_rom_index(logic [ADDR_W-1:0] a);
		logic [ROM_IDX_W-1:0] idx;
		logic [4:0]           lg;
		idx = ROM_IDX_W'(a);
		if ((shadow_mode == MODE_MBC1 || shadow_mode == MODE_MBC2) && a[14]) begin
			idx[14] = 1'b0;
			idx = idx | (ROM_IDX_W'(shadow_bank) << BANK_SHIFT);
		end
		lg = shadow_rom_lg;
		if (lg < ROM_LG_MIN) lg = ROM_LG_MIN;
		if (lg > ROM_LG_MAX) lg = ROM_LG_MAX;
		return idx & ((ROM_IDX_W'(1) << lg) - ROM_IDX_W'(1));
	endfunction

	// Apply one bus access to the shadow state and return its result beat
	function automatic access_result_t map_access(cmd_t c, logic [ADDR_W-1:0] a,
		logic [7:0] v, logic b);
		access_result_t r;
		logic           ram_live;
		r = NO_RESULT;
		ram_live = (shadow_mode == MODE_MBC2) && shadow_ram_en;
		case (c)
			CMD_ROM_RD: begin
				r.rom_index = physical_rom_index(a);
			end
			CMD_ROM_WR: begin
				r.rom_index = physical_rom_index(a);
				// A debug poke touches the external ROM only
				if (b) begin
					r.rom_poke = 1'b1;
				end else if (shadow_mode == MODE_MBC1) begin
					if (a[14:13] == WIN_BANK)
						shadow_bank = (a[14:13] == WIN_BANK && v[4:0] == 5'd0) ? 5'd1 : v[4:0];
				end else if (shadow_mode == MODE_MBC2) begin
					if (a[14:13] == WIN_RAM_EN)
						shadow_ram_en = a[8];
					else if (a[14:13] == WIN_BANK)
						shadow_bank = (v[3:0] == 4'd0) ? 5'd1 : {1'b0, v[3:0]};
				end
			end
			CMD_RAM_RD: begin
				if (ram_live) r.read_data = shadow_ram[a[8:0]];
			end
			default: begin
				if (ram_live) shadow_ram[a[8:0]] = b ? v : {4'h0, v[3:0]};
			end
		endcase
		return r;
	endfunction

	// Score result beats, track register writes and predict accepted beats.
	// Check before predicting so a beat taken this edge never answers itself.
	always @(posedge clk) begin : scoreboard
		access_result_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pending_results.size() == 0) begin
					$display("%0t: unexpected result beat, expected none, actual %h/%b/%h",
						$time, rom_index, rom_poke, read_data);
					errors++;
				end else begin
					want = pending_results.pop_front();
					if (rom_index !== want.rom_index) begin
						$display("%0t: rom_index expected %h actual %h",
							$time, want.rom_index, rom_index);
						errors++;
					end
					if (rom_poke !== want.rom_poke) begin
						$display("%0t: rom_poke expected %b actual %b",
							$time, want.rom_poke, rom_poke);
						errors++;
					end
					if (read_data !== want.read_data) begin
						$display("%0t: read_data expected %h actual %h",
							$time, want.read_data, read_data);
						errors++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_MAPPER_MODE: shadow_mode = cfg_data[1:0];
					default:         shadow_rom_lg = cfg_data;
				endcase
			end
			if (in_valid && !in_stall) begin
				want = map_access(cmd_t'(command), address, value, bypass);
				if (beat_typed) want = beat_result;
				pending_results.push_back(want);
			end
		end
	end

	// Result side: stall at random, except through the full-rate phase
	always @(posedge clk) begin
		out_stall <= no_idle ? 1'b0 : ($urandom_range(99) < IDLE_PCT);
	end

	// End the run when no channel has moved a beat for too long
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("cartridge_bank_mapper_core verification failed");
			$finish;
		end
	end

	// Drop valid and hold until every predicted result has come back.
	// Wait for the scoreboard to queue the beat taken at this edge before checking.
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// Write both registers back to back; the mode gets random upper bits
	task automatic write_config(logic [1:0] mode, logic [4:0] lg);
		cfg_valid <= 1'b1;
		cfg_index <= REG_MAPPER_MODE;
		cfg_data  <= {3'($urandom_range(7)), mode};
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= REG_ROM_SIZE;
		cfg_data  <= lg;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// Present one access beat after a random gap and hold it until taken
	task automatic send_access(cmd_t c, logic [ADDR_W-1:0] a, logic [7:0] v, logic b,
		logic typed, access_result_t r);
		while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		command     <= c;
		address     <= a;
		value       <= v;
		bypass      <= b;
		beat_typed  <= typed;
		beat_result <= r;
		do @(posedge clk); while (in_stall);
	endtask

	// Mostly well-formed traffic: bank and enable writes land in their
	// windows, RAM accesses cluster on a few entries to hit earlier writes
	task automatic random_access(output cmd_t c, output logic [ADDR_W-1:0] a,
		output logic [7:0] v, output logic b);
		int unsigned pick;
		pick = $urandom_range(99);
		a = ADDR_W'($urandom);
		v = 8'($urandom);
		b = 1'($urandom);
		if (pick < 30) begin
			c = CMD_ROM_RD;
		end else if (pick < 55) begin
			c = CMD_ROM_WR;
			b = ($urandom_range(9) == 0);
			pick = $urandom_range(99);
			if (pick < 40) begin
				a[14:13] = WIN_BANK;
			end else if (pick < 75) begin
				a[14:13] = WIN_RAM_EN;
				a[8] = ($urandom_range(9) < 7);
			end
			if ($urandom_range(9) == 0) v[4:0] = 5'd0;
		end else begin
			c = (pick < 75) ? CMD_RAM_RD : CMD_RAM_WR;
			if ($urandom_range(1) == 1) a[8:0] = 9'($urandom_range(15));
		end
	endtask

	initial begin
		logic [1:0]        cur_mode;
		logic [4:0]        cur_lg;
		cmd_t              c;
		logic [ADDR_W-1:0] a;
		logic [7:0]        v;
		logic              b;

		cur_mode = MODE_NONE;
		cur_lg   = ROM_LG_MIN;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Directed rows; reconfigure only once the block has gone idle
		foreach (STIM_ROWS[i]) begin
			if (STIM_ROWS[i].mode != cur_mode || STIM_ROWS[i].rom_lg != cur_lg) begin
				drain_results();
				write_config(STIM_ROWS[i].mode, STIM_ROWS[i].rom_lg);
				cur_mode = STIM_ROWS[i].mode;
				cur_lg   = STIM_ROWS[i].rom_lg;
			end
			send_access(STIM_ROWS[i].cmd, STIM_ROWS[i].addr, STIM_ROWS[i].val,
				STIM_ROWS[i].byp, STIM_ROWS[i].typed, STIM_ROWS[i].res);
		end

		// Random phases, one configuration each
		for (int unsigned p = 0; p < PHASES; p++) begin
			drain_results();
			write_config(PHASE_MODE[p], PHASE_LG[p]);
			// Run one phase at full rate on both sides
			no_idle = (p == 4);
			for (int unsigned k = 0; k < PHASE_BEATS; k++) begin
				// Hold the sender mid-phase until the pipeline is empty
				if (k == PHASE_BEATS / 2) drain_results();
				random_access(c, a, v, b);
				send_access(c, a, v, b, 1'b0, NO_RESULT);
			end
		end
		no_idle = 1'b0;

		drain_results();
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("cartridge_bank_mapper_core verification clean");
		else
			$display("cartridge_bank_mapper_core verification failed");
		$finish;
	end

endmodule
